/* src/freshest_per_key_filter_unit_assert.svh */
// Assertion macros for the filter RTL.
`ifndef FRESHEST_PER_KEY_FILTER_UNIT_ASSERT_SVH
`define FRESHEST_PER_KEY_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define FFK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define FFK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ffk_pkg.sv */
`timescale 1ns / 1ps
package ffk_pkg;
  localparam int BATCH_SLOTS = 32;
  localparam int KEY_SLOTS   = 64;
  localparam int FIELD_W     = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] gen;
    logic [FIELD_W-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_UPDATE,
    OP_SHIFT
  } batch_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_DRAIN
  } state_t;

  // Broadcast from the controller to every applied-table cell.
  typedef struct packed {
    logic               record;
    logic               any_match;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] gen;
  } applied_ctrl_t;
endpackage

/* src/ffk_batch_cell.sv */
`timescale 1ns / 1ps
module ffk_batch_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ffk_pkg::batch_op_t op,
  input  ffk_pkg::entry_t   new_e,
  input  ffk_pkg::entry_t   left_e,
  input  logic              left_valid,
  input  logic              left_after,
  input  ffk_pkg::entry_t   right_e,
  input  logic              right_valid,
  output ffk_pkg::entry_t   cur_e,
  output logic              valid,
  output logic              after,
  output logic              match
);
  ffk_pkg::entry_t ent_r;
  logic            valid_r;

  assign cur_e = ent_r;
  assign valid = valid_r;
  // Empty cells sit after every key, so the row stays sorted.
  assign after = !valid_r || (ent_r.key > new_e.key);
  assign match = valid_r && (ent_r.key == new_e.key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (op)
        ffk_pkg::OP_INSERT: begin
          if (after && !left_after) valid_r <= 1'b1;
          else if (after) valid_r <= left_valid;
        end
        ffk_pkg::OP_SHIFT: valid_r <= right_valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      ffk_pkg::OP_INSERT: begin
        if (after && !left_after) ent_r <= new_e;
        else if (after) ent_r <= left_e;
      end
      ffk_pkg::OP_UPDATE: begin
        if (match && (new_e.gen > ent_r.gen)) begin
          ent_r.gen <= new_e.gen;
          ent_r.tag <= new_e.tag;
        end
      end
      ffk_pkg::OP_SHIFT: ent_r <= right_e;
      default: ;
    endcase
  end
endmodule

/* src/ffk_applied_cell.sv */
`timescale 1ns / 1ps
module ffk_applied_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffk_pkg::applied_ctrl_t ctrl,
  input  logic                  free_before,
  output logic                  free_seen,
  output logic                  match,
  output logic                  stale
);
  logic [ffk_pkg::FIELD_W-1:0] key_r;
  logic [ffk_pkg::FIELD_W-1:0] gen_r;
  logic                        valid_r;
  logic                        wr;

  assign match     = valid_r && (key_r == ctrl.key);
  assign stale     = match && (ctrl.gen < gen_r);
  assign free_seen = free_before || !valid_r;
  // Take the word on a key hit, else claim the first free cell.
  assign wr = ctrl.record && (match || (!ctrl.any_match && !valid_r && !free_before));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_r <= ctrl.key;
      gen_r <= ctrl.gen;
    end
  end
endmodule

/* src/freshest_per_key_filter_unit.sv */
`timescale 1ns / 1ps
// Freshest-per-key filter.
// Input channel in_*: one word per request. in_tuser is the request kind
// (0 add, 1 drain); in_tdata holds key, generation and tag.
// Output channel out_*: one word per survivor, in ascending key order, with
// out_tlast on the final word of a drain. An empty drain gives a single word
// flagged none_survived with zero data.
// An add is looked up in the applied table, then updates the batch row;
// no new request is taken until the update is done. A drain emits one word
// per survivor (or one for an empty drain) as the batch row shifts one cell
// per word; the first word passes through the S_DRAIN state and the output register.
// A stalled receiver holds the output register and freezes the drain; the
// block still accepts adds while a finished word waits.
// Reset clears the batch, the applied table and the overflow flag at once.
// Batch overflow and applied-table exhaustion are flagged, not handled.
module freshest_per_key_filter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // entry_key, entry_generation, entry_tag
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // out_key, out_generation, out_tag
  output logic         out_tlast,  // last
  output logic [2:0]   out_tuser   // none_survived, batch_overflow, table_full
);
  localparam int NB = ffk_pkg::BATCH_SLOTS;
  localparam int NK = ffk_pkg::KEY_SLOTS;

  ffk_pkg::state_t state_r, state_nxt;
  ffk_pkg::entry_t entry_r, entry_nxt, in_e;
  logic            stale_r, stale_nxt;
  logic            ovf_r, ovf_nxt;
  logic            drain_ovf_r, drain_ovf_nxt;

  ffk_pkg::batch_op_t op;
  ffk_pkg::entry_t    b_e   [NB+1];
  logic [NB:0]        b_valid;
  logic [NB-1:0]      b_after;
  logic [NB-1:0]      b_match;

  ffk_pkg::applied_ctrl_t actrl;
  logic [NK:0]            a_free;
  logic [NK-1:0]          a_match, a_stale;

  logic         out_valid_r, out_valid_nxt;
  logic [191:0] out_data_r, out_data_nxt;
  logic         out_last_r, out_last_nxt;
  logic [2:0]   out_user_r, out_user_nxt;
  logic         out_free;

  assign in_e      = '{key: in_tdata[63:0], gen: in_tdata[127:64], tag: in_tdata[191:128]};
  assign in_tready = (state_r == ffk_pkg::S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Batch row: sorted by key, cell 0 holds the smallest.
  assign b_e[NB]     = '0;
  assign b_valid[NB] = 1'b0;

  for (genvar i = 0; i < NB; i++) begin : g_batch
    ffk_pkg::entry_t l_e;
    logic            l_valid, l_after;
    if (i == 0) begin : g_first
      assign l_e     = '0;
      assign l_valid = 1'b0;
      assign l_after = 1'b0;
    end else begin : g_rest
      assign l_e     = b_e[i-1];
      assign l_valid = b_valid[i-1];
      assign l_after = b_after[i-1];
    end
    ffk_batch_cell u_cell (
      .clk, .rst_n, .op, .new_e(entry_r),
      .left_e(l_e), .left_valid(l_valid), .left_after(l_after),
      .right_e(b_e[i+1]), .right_valid(b_valid[i+1]),
      .cur_e(b_e[i]), .valid(b_valid[i]), .after(b_after[i]), .match(b_match[i])
    );
  end

  // Applied table: lookup key comes from the input on an add, cell 0 on a drain.
  assign a_free[0] = 1'b0;
  for (genvar j = 0; j < NK; j++) begin : g_applied
    ffk_applied_cell u_cell (
      .clk, .rst_n, .ctrl(actrl), .free_before(a_free[j]),
      .free_seen(a_free[j+1]), .match(a_match[j]), .stale(a_stale[j])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    entry_nxt     = entry_r;
    stale_nxt     = stale_r;
    ovf_nxt       = ovf_r;
    drain_ovf_nxt = drain_ovf_r;
    op            = ffk_pkg::OP_HOLD;
    actrl         = '{record: 1'b0, any_match: 1'b0, key: in_e.key, gen: in_e.gen};
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;
    if (state_r == ffk_pkg::S_DRAIN) begin
      actrl.key = b_e[0].key;
      actrl.gen = b_e[0].gen;
    end
    actrl.any_match = |a_match;

    unique case (state_r)
      ffk_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            drain_ovf_nxt = ovf_r;
            state_nxt     = ffk_pkg::S_DRAIN;
          end else begin
            entry_nxt = in_e;
            stale_nxt = |a_stale;
            state_nxt = ffk_pkg::S_ADD;
          end
        end
      end
      ffk_pkg::S_ADD: begin
        if (!stale_r) begin
          if (|b_match)        op = ffk_pkg::OP_UPDATE;
          else if (b_valid[NB-1]) ovf_nxt = 1'b1;
          else                 op = ffk_pkg::OP_INSERT;
        end
        state_nxt = ffk_pkg::S_IDLE;
      end
      ffk_pkg::S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (b_valid[0]) begin
            op           = ffk_pkg::OP_SHIFT;
            actrl.record = 1'b1;
            out_data_nxt = {b_e[0].tag, b_e[0].gen, b_e[0].key};
            out_last_nxt = !b_valid[1];
            out_user_nxt = {!(|a_match) && !a_free[NK], drain_ovf_r, 1'b0};
          end else begin
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            out_user_nxt = {1'b0, drain_ovf_r, 1'b1};
          end
          if (!b_valid[1] || !b_valid[0]) begin
            ovf_nxt   = 1'b0;
            state_nxt = ffk_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = ffk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffk_pkg::S_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r     <= entry_nxt;
    stale_r     <= stale_nxt;
    drain_ovf_r <= drain_ovf_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`include "freshest_per_key_filter_unit_assert.svh"
  `FFK_ASSERT_IMPL(a_none_is_last, out_tvalid && out_tuser[0], out_tlast, "empty drain not last")
  `FFK_ASSERT_IMPL(a_none_zero, out_tvalid && out_tuser[0], out_tdata == '0 && !out_tuser[2], "empty has data")
  `FFK_ASSERT_NEXT(a_add_two_cycles, state_r == ffk_pkg::S_ADD, state_r == ffk_pkg::S_IDLE, "add stuck")
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [63:0] key;
    logic [63:0] gen;
    logic [63:0] tag;
    logic        last;
    logic [2:0]  flags;  // none_survived, batch_overflow, table_full
  } survivor_t;

  // Filter predictor and queue of expected survivor words.
  class freshest_scoreboard;
    logic [63:0] bkey [ffk_pkg::BATCH_SLOTS];
    logic [63:0] bgen [ffk_pkg::BATCH_SLOTS];
    logic [63:0] btag [ffk_pkg::BATCH_SLOTS];
    bit          bval [ffk_pkg::BATCH_SLOTS];
    logic [63:0] akey [ffk_pkg::KEY_SLOTS];
    logic [63:0] agen [ffk_pkg::KEY_SLOTS];
    bit          aval [ffk_pkg::KEY_SLOTS];
    bit          ovf;
    survivor_t   pending [$];
    int          mismatches;
    int          words_seen;

    function void clear();
      foreach (bval[i]) bval[i] = 0;
      foreach (aval[i]) aval[i] = 0;
      ovf = 0;
      pending.delete();
      mismatches = 0;
      words_seen = 0;
    endfunction

    function int applied_slot(logic [63:0] k);
      foreach (aval[i]) if (aval[i] && akey[i] == k) return i;
      return -1;
    endfunction

    function void note_request(bit drain, logic [63:0] k, logic [63:0] g,
                               logic [63:0] t);
      int a;
      int free_i;
      int order [$];
      int j;
      survivor_t s;
      free_i = -1;
      if (!drain) begin
        a = applied_slot(k);
        if (a >= 0 && g < agen[a]) return;
        for (int i = 0; i < ffk_pkg::BATCH_SLOTS; i++) begin
          if (bval[i]) begin
            if (bkey[i] == k) begin
              if (g > bgen[i]) begin
                bgen[i] = g;
                btag[i] = t;
              end
              return;
            end
          end else if (free_i < 0) begin
            free_i = i;
          end
        end
        if (free_i < 0) begin
          ovf = 1;
          return;
        end
        bkey[free_i] = k;
        bgen[free_i] = g;
        btag[free_i] = t;
        bval[free_i] = 1;
        return;
      end
      // Drain: sort survivors by key, first slot first on ties (keys unique).
      for (int i = 0; i < ffk_pkg::BATCH_SLOTS; i++) begin
        if (bval[i]) begin
          j = 0;
          while (j < order.size() && bkey[order[j]] <= bkey[i]) j++;
          order.insert(j, i);
        end
      end
      if (order.size() == 0) begin
        s = '{64'd0, 64'd0, 64'd0, 1'b1, {1'b0, ovf, 1'b1}};
        pending.insert(pending.size(), s);
      end
      foreach (order[n]) begin
        s.key = bkey[order[n]];
        s.gen = bgen[order[n]];
        s.tag = btag[order[n]];
        s.last = (n == order.size() - 1);
        a = applied_slot(s.key);
        if (a < 0)
          for (int i = 0; i < ffk_pkg::KEY_SLOTS; i++)
            if (!aval[i]) begin
              a = i;
              break;
            end
        s.flags = {(a < 0), ovf, 1'b0};
        if (a >= 0) begin
          akey[a] = s.key;
          agen[a] = s.gen;
          aval[a] = 1;
        end
        pending.insert(pending.size(), s);
      end
      foreach (bval[i]) bval[i] = 0;
      ovf = 0;
    endfunction

    function void check_word(logic [191:0] d, logic l, logic [2:0] u);
      survivor_t e;
      words_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", d);
        return;
      end
      e = pending.pop_front();
      if (d !== {e.tag, e.gen, e.key} || l !== e.last || u !== e.flags) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp k=%h g=%h t=%h l=%b u=%b got k=%h g=%h t=%h l=%b u=%b",
                   e.key, e.gen, e.tag, e.last, e.flags,
                   d[63:0], d[127:64], d[191:128], l, u);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [191:0] out_tdata;
  logic         out_tlast;
  logic [2:0]   out_tuser;

  freshest_scoreboard board;
  longint cycles = 0;
  int     burst_left = 0;
  logic [63:0] key_pool [8];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  freshest_per_key_filter_unit uut (.*);

  // Note accepted words on the predictor, check every result word.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready)
      board.note_request(in_tuser, in_tdata[63:0], in_tdata[127:64], in_tdata[191:128]);
    if (rst_n && out_tvalid && out_tready)
      board.check_word(out_tdata, out_tlast, out_tuser);
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver stalls: long runs of ready, then patches of random stalls.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (cycles[9]) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Send one word; hold valid until accepted. Gaps come between bursts.
  task automatic send_word(bit drain, logic [63:0] k, logic [63:0] g, logic [63:0] t);
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tuser  <= drain;
    in_tdata  <= {t, g, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic add_entry(logic [63:0] k, logic [63:0] g, logic [63:0] t);
    send_word(0, k, g, t);
  endtask

  task automatic drain_batch();
    send_word(1, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] k;
    logic [63:0] g;
    int n;
    board = new();
    board.clear();
    foreach (key_pool[i]) key_pool[i] = rand64();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty drain, extremes, ties, stale entries, key order.
    drain_batch();
    add_entry('1, '1, '1);
    add_entry('0, '0, '0);
    add_entry(64'd5, 64'd10, 64'hA);
    add_entry(64'd5, 64'd10, 64'hB);     // equal generation: first kept
    add_entry(64'd5, 64'd12, 64'hC);     // newer wins
    add_entry(64'd5, 64'd11, 64'hD);     // older within batch loses
    add_entry(64'd3, 64'd1, 64'h3);
    drain_batch();
    add_entry(64'd5, 64'd11, 64'hE);     // stale against applied
    add_entry(64'd5, 64'd12, 64'hF);     // equal to applied: kept
    add_entry('1, 64'hFFFF_FFFF_FFFF_FFFE, 64'h1);  // stale
    drain_batch();
    // Batch overflow: 33 distinct keys.
    for (int i = 0; i < ffk_pkg::BATCH_SLOTS + 1; i++)
      add_entry(64'h100 + 64'(i), 64'(i), rand64());
    drain_batch();
    drain_batch();                       // empty, overflow flag cleared

    // Random: mostly small key pool so staleness and ties occur.
    for (int it = 0; it < 60; it++) begin
      if ($urandom_range(0, 7) == 0) begin
        drain_batch();
      end else begin
        if ($urandom_range(0, 3) == 0) k = rand64();
        else k = key_pool[$urandom_range(0, 7)];
        g = ($urandom_range(0, 1)) ? {60'd0, 4'($urandom)} : rand64();
        add_entry(k, g, rand64());
      end
    end
    drain_batch();
    // Fill the applied table beyond its 64 slots to reach table-full.
    for (int r = 0; r < 2; r++) begin
      n = $urandom_range(20, ffk_pkg::BATCH_SLOTS);
      for (int i = 0; i < n; i++) add_entry(rand64(), rand64(), rand64());
      drain_batch();
    end
    in_tvalid <= 0;
    @(posedge clk);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/ffk_pkg.sv
src/ffk_batch_cell.sv
src/ffk_applied_cell.sv
src/freshest_per_key_filter_unit.sv
verif/tb.sv
